/* rtl/sdlf_pkg.sv */
package sdlf_pkg;

  localparam int FRAC_BITS = 16;
  localparam int STEPS_PER_TICK_DEF = 10;

  // field and register widths
  localparam int TGT_W = 17;
  localparam int DT_W = 16;
  localparam int LEVEL_W = 18;
  localparam int VEL_W = 20;
  localparam int TRAIL_W = 24;
  localparam int GAIN_W = 24;
  localparam int SNAP_W = 19;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W = 24;

  // shared multiplier: signed A operand times unsigned B operand
  localparam int MUL_A_W = 44;
  localparam int MUL_B_W = 24;
  localparam int MUL_LO_W = 22;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // working velocity before the clamp
  localparam int VW_W = 42;

  localparam int ONE_Q = 1 << FRAC_BITS;
  localparam int LOW_CLAMP = -((ONE_Q + 5) / 10);
  localparam int HIGH_CLAMP = (11 * ONE_Q + 5) / 10;

  localparam logic KIND_SET = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_SPRING = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VISC = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SNAP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VFLOOR = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_VCEIL = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BOUNCE = 3'd5;

  localparam logic [GAIN_W-1:0] SPRING_RST = 24'd65536;
  localparam logic [GAIN_W-1:0] VISC_RST = 24'd65536;
  localparam logic [SNAP_W-1:0] SNAP_RST = 19'd65536;
  localparam logic signed [VEL_W-1:0] VFLOOR_RST = -20'sd65536;
  localparam logic signed [VEL_W-1:0] VCEIL_RST = 20'sd65536;

  typedef enum logic [3:0] {
    S_IDLE,
    S_GAP,
    S_MUL,
    S_FORCE,
    S_ACCEL,
    S_DAMP,
    S_DRAG,
    S_MOVE,
    S_FINAL,
    S_RESULT
  } state_e;

  typedef struct packed {
    logic                      go;
    logic signed [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0]        b;
  } mul_req_t;

  typedef struct packed {
    logic                      done;
    logic signed [MUL_P_W-1:0] p;
  } mul_rsp_t;

endpackage

/* rtl/sdlf_in_if.sv */
interface sdlf_in_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [sdlf_pkg::TGT_W-1:0]  target_value;
  logic [sdlf_pkg::DT_W-1:0]   time_step;

  modport source (output valid, kind, target_value, time_step, input ready);
  modport sink (input valid, kind, target_value, time_step, output ready);
endinterface

/* rtl/sdlf_out_if.sv */
interface sdlf_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [sdlf_pkg::LEVEL_W-1:0] shown_level;
  logic signed [sdlf_pkg::VEL_W-1:0]   velocity_now;

  modport source (output valid, shown_level, velocity_now, input ready);
  modport sink (input valid, shown_level, velocity_now, output ready);
endinterface

/* rtl/spring_damped_level_follower_core.sv */
// Channel  Dir  Handshake     Payload
// in_i     in   valid/ready   kind, target_value, time_step
// out_o    out  valid/ready   shown_level, velocity_now
// cfg      in   cfg_we_i      cfg_idx_i, cfg_data_i (write only)
//
// Set item: updates velocity and target, then the result. Tick item: STEPS_PER_TICK steps, final clamp, result.
// Step: snap velocity at a target edge, spring only in bounce mode, spring and damping otherwise;
// each multiply uses the shared 23x25 multiplier, a low then a high pass if the A operand is wider.
// One item at a time; ready only when idle. A finished result waits in the
// output register while the next item is taken.
// Async active-low reset clears state and loads register defaults.
module spring_damped_level_follower_core #(
  parameter int STEPS_PER_TICK = sdlf_pkg::STEPS_PER_TICK_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  sdlf_in_if.sink                        in_i,
  sdlf_out_if.source                     out_o,
  input  logic                           cfg_we_i,
  input  logic [sdlf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [sdlf_pkg::CFG_W-1:0]     cfg_data_i
);

  localparam int FRAC = sdlf_pkg::FRAC_BITS;
  localparam int A_W = sdlf_pkg::MUL_A_W;
  localparam int B_W = sdlf_pkg::MUL_B_W;
  localparam int VW_W = sdlf_pkg::VW_W;
  localparam int VEL_W = sdlf_pkg::VEL_W;
  localparam int TRAIL_W = sdlf_pkg::TRAIL_W;
  localparam int TGT_W = sdlf_pkg::TGT_W;
  localparam int DT_W = sdlf_pkg::DT_W;
  localparam int LEVEL_W = sdlf_pkg::LEVEL_W;
  localparam int GAIN_W = sdlf_pkg::GAIN_W;
  localparam int SNAP_W = sdlf_pkg::SNAP_W;
  localparam int CNT_W = (STEPS_PER_TICK > 1) ? $clog2(STEPS_PER_TICK) : 1;
  localparam logic [CNT_W-1:0] LAST = CNT_W'(STEPS_PER_TICK - 1);
  localparam int TS_W = TRAIL_W + 2;
  localparam int JS_W = VEL_W + 2;
  localparam logic signed [TS_W-1:0] T_MAX = {3'b000, {(TRAIL_W-1){1'b1}}};
  localparam logic signed [TS_W-1:0] T_MIN = {3'b111, {(TRAIL_W-1){1'b0}}};
  localparam logic signed [JS_W-1:0] J_MAX = {3'b000, {(VEL_W-1){1'b1}}};
  localparam logic signed [JS_W-1:0] J_MIN = {3'b111, {(VEL_W-1){1'b0}}};
  localparam logic signed [TRAIL_W-1:0] LVL_LO = TRAIL_W'(sdlf_pkg::LOW_CLAMP);
  localparam logic signed [TRAIL_W-1:0] LVL_HI = TRAIL_W'(sdlf_pkg::HIGH_CLAMP);

  function automatic logic signed [VEL_W-1:0] vclamp(
    input logic signed [VW_W-1:0]  x,
    input logic signed [VEL_W-1:0] lo,
    input logic signed [VEL_W-1:0] hi
  );
    logic signed [VW_W-1:0] lo_x;
    logic signed [VW_W-1:0] hi_x;
    lo_x = VW_W'(lo);
    hi_x = VW_W'(hi);
    if (x < lo_x) begin
      return lo;
    end else if (x > hi_x) begin
      return hi;
    end else begin
      return VEL_W'(x);
    end
  endfunction

  // configuration
  logic [GAIN_W-1:0]       spring_q, visc_q;
  logic [SNAP_W-1:0]       snap_q;
  logic signed [VEL_W-1:0] vfloor_q, vceil_q;
  logic                    bounce_q;

  // control
  sdlf_pkg::state_e state_q, state_d, ret_q, ret_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             bound_q, bound_d;
  logic             out_valid_q, out_valid_d;
  logic             out_load;
  logic             accept;

  // datapath
  logic [TGT_W-1:0]          tgt_q, tgt_d;
  logic signed [TRAIL_W-1:0] trail_q, trail_d;
  logic signed [VEL_W-1:0]   vel_q, vel_d;
  logic signed [VW_W-1:0]    vw_q, vw_d;
  logic signed [A_W-1:0]     opa_q, opa_d;
  logic [B_W-1:0]            opb_q, opb_d;
  logic [DT_W-1:0]           dt_q, dt_d;
  logic signed [LEVEL_W-1:0] out_level_q;
  logic signed [VEL_W-1:0]   out_vel_q;

  logic signed [TS_W-1:0]    gap_w;
  logic signed [TS_W-1:0]    tsum;
  logic signed [JS_W-1:0]    jsum;
  logic signed [A_W-1:0]     scaled;
  logic signed [VW_W-1:0]    vsum;
  logic signed [VEL_W-1:0]   vc;
  logic [B_W-1:0]            dt_b;

  sdlf_pkg::mul_req_t mul_req;
  sdlf_pkg::mul_rsp_t mul_rsp;

  sdlf_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  assign mul_req.go = (state_q == sdlf_pkg::S_MUL);
  assign mul_req.a = opa_q;
  assign mul_req.b = opb_q;

  assign in_i.ready = (state_q == sdlf_pkg::S_IDLE);
  assign accept = in_i.valid & in_i.ready;

  assign scaled = A_W'(mul_rsp.p >>> FRAC);
  assign dt_b = B_W'(dt_q);
  assign gap_w = TS_W'(signed'({1'b0, tgt_q})) - TS_W'(trail_q);
  assign tsum = TS_W'(trail_q) + TS_W'(scaled);
  assign jsum = JS_W'(vel_q) + JS_W'(signed'({1'b0, in_i.target_value}))
              - JS_W'(signed'({1'b0, tgt_q}));

  always_comb begin
    unique case (state_q)
      sdlf_pkg::S_GAP: begin
        if (gap_w > 0) begin
          vsum = VW_W'(signed'({1'b0, snap_q}));
        end else if (gap_w < 0) begin
          vsum = -VW_W'(signed'({1'b0, snap_q}));
        end else begin
          vsum = '0;
        end
      end
      sdlf_pkg::S_ACCEL: vsum = VW_W'(vel_q) + VW_W'(scaled);
      default:           vsum = vw_q + VW_W'(scaled);
    endcase
  end

  assign vc = vclamp(vsum, vfloor_q, vceil_q);

  always_comb begin
    state_d = state_q;
    ret_d = ret_q;
    cnt_d = cnt_q;
    bound_d = bound_q;
    tgt_d = tgt_q;
    trail_d = trail_q;
    vel_d = vel_q;
    vw_d = vw_q;
    opa_d = opa_q;
    opb_d = opb_q;
    dt_d = dt_q;
    out_load = 1'b0;

    unique case (state_q)
      sdlf_pkg::S_IDLE: begin
        if (accept) begin
          if (in_i.kind == sdlf_pkg::KIND_SET) begin
            if (jsum > J_MAX) begin
              vel_d = J_MAX[VEL_W-1:0];
            end else if (jsum < J_MIN) begin
              vel_d = J_MIN[VEL_W-1:0];
            end else begin
              vel_d = jsum[VEL_W-1:0];
            end
            tgt_d = in_i.target_value;
            state_d = sdlf_pkg::S_RESULT;
          end else begin
            dt_d = in_i.time_step;
            bound_d = (tgt_q == '0) | tgt_q[TGT_W-1];
            cnt_d = '0;
            state_d = sdlf_pkg::S_GAP;
          end
        end
      end
      sdlf_pkg::S_GAP: begin
        if (bound_q) begin
          vel_d = vc;
          opa_d = A_W'(vc);
          opb_d = dt_b;
          ret_d = sdlf_pkg::S_MOVE;
        end else begin
          opa_d = A_W'(gap_w);
          opb_d = spring_q;
          ret_d = sdlf_pkg::S_FORCE;
        end
        state_d = sdlf_pkg::S_MUL;
      end
      sdlf_pkg::S_MUL: begin
        if (mul_rsp.done) begin
          state_d = ret_q;
        end
      end
      sdlf_pkg::S_FORCE: begin
        opa_d = scaled;
        opb_d = dt_b;
        ret_d = sdlf_pkg::S_ACCEL;
        state_d = sdlf_pkg::S_MUL;
      end
      sdlf_pkg::S_ACCEL: begin
        if (bounce_q) begin
          vel_d = vc;
          opa_d = A_W'(vc);
          opb_d = dt_b;
          ret_d = sdlf_pkg::S_MOVE;
        end else begin
          vw_d = vsum;
          opa_d = -A_W'(vel_q) - scaled;
          opb_d = visc_q;
          ret_d = sdlf_pkg::S_DAMP;
        end
        state_d = sdlf_pkg::S_MUL;
      end
      sdlf_pkg::S_DAMP: begin
        opa_d = scaled;
        opb_d = dt_b;
        ret_d = sdlf_pkg::S_DRAG;
        state_d = sdlf_pkg::S_MUL;
      end
      sdlf_pkg::S_DRAG: begin
        vel_d = vc;
        opa_d = A_W'(vc);
        opb_d = dt_b;
        ret_d = sdlf_pkg::S_MOVE;
        state_d = sdlf_pkg::S_MUL;
      end
      sdlf_pkg::S_MOVE: begin
        if (tsum > T_MAX) begin
          trail_d = T_MAX[TRAIL_W-1:0];
        end else if (tsum < T_MIN) begin
          trail_d = T_MIN[TRAIL_W-1:0];
        end else begin
          trail_d = tsum[TRAIL_W-1:0];
        end
        if (cnt_q == LAST) begin
          state_d = sdlf_pkg::S_FINAL;
        end else begin
          cnt_d = cnt_q + 1'b1;
          state_d = sdlf_pkg::S_GAP;
        end
      end
      sdlf_pkg::S_FINAL: begin
        if (trail_q < LVL_LO) begin
          trail_d = LVL_LO;
        end else if (trail_q > LVL_HI) begin
          trail_d = LVL_HI;
        end
        state_d = sdlf_pkg::S_RESULT;
      end
      sdlf_pkg::S_RESULT: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d = sdlf_pkg::S_IDLE;
        end
      end
      default: state_d = sdlf_pkg::S_IDLE;
    endcase
  end

  assign out_valid_d = out_load | (out_valid_q & ~out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sdlf_pkg::S_IDLE;
      ret_q <= sdlf_pkg::S_IDLE;
      cnt_q <= '0;
      bound_q <= 1'b0;
      tgt_q <= '0;
      trail_q <= '0;
      vel_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q <= ret_d;
      cnt_q <= cnt_d;
      bound_q <= bound_d;
      tgt_q <= tgt_d;
      trail_q <= trail_d;
      vel_q <= vel_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    vw_q <= vw_d;
    opa_q <= opa_d;
    opb_q <= opb_d;
    dt_q <= dt_d;
    if (out_load) begin
      out_level_q <= trail_q[LEVEL_W-1:0];
      out_vel_q <= vel_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spring_q <= sdlf_pkg::SPRING_RST;
      visc_q <= sdlf_pkg::VISC_RST;
      snap_q <= sdlf_pkg::SNAP_RST;
      vfloor_q <= sdlf_pkg::VFLOOR_RST;
      vceil_q <= sdlf_pkg::VCEIL_RST;
      bounce_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sdlf_pkg::CFG_SPRING: spring_q <= cfg_data_i[GAIN_W-1:0];
        sdlf_pkg::CFG_VISC:   visc_q <= cfg_data_i[GAIN_W-1:0];
        sdlf_pkg::CFG_SNAP:   snap_q <= cfg_data_i[SNAP_W-1:0];
        sdlf_pkg::CFG_VFLOOR: vfloor_q <= cfg_data_i[VEL_W-1:0];
        sdlf_pkg::CFG_VCEIL:  vceil_q <= cfg_data_i[VEL_W-1:0];
        sdlf_pkg::CFG_BOUNCE: bounce_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.shown_level = out_level_q;
  assign out_o.velocity_now = out_vel_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != sdlf_pkg::S_IDLE)
    else $error("item accepted but sequencer stayed idle");

  a_step_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= LAST)
    else $error("step counter out of range");

  a_mul_only_in_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_rsp.done |-> state_q == sdlf_pkg::S_MUL &&
                     (ret_q == sdlf_pkg::S_FORCE || ret_q == sdlf_pkg::S_ACCEL ||
                      ret_q == sdlf_pkg::S_DAMP || ret_q == sdlf_pkg::S_DRAG ||
                      ret_q == sdlf_pkg::S_MOVE))
    else $error("multiply finished with no write-back step");

endmodule

/* rtl/sdlf_mul.sv */
module sdlf_mul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sdlf_pkg::mul_req_t req_i,
  output sdlf_pkg::mul_rsp_t rsp_o
);

  localparam int A_W = sdlf_pkg::MUL_A_W;
  localparam int B_W = sdlf_pkg::MUL_B_W;
  localparam int P_W = sdlf_pkg::MUL_P_W;
  localparam int LO_W = sdlf_pkg::MUL_LO_W;
  localparam int PART_W = LO_W + 1;
  localparam int HI_W = A_W - LO_W;

  logic                      hi_pass_q, hi_pass_d;
  logic                      fits;
  logic signed [PART_W-1:0]  part;
  logic signed [PART_W+B_W:0] prod;
  logic signed [P_W-1:0]     prod_ext;
  logic signed [P_W-1:0]     p_q, p_d;

  // A that fits the signed part width is multiplied whole, else low then high half
  assign fits = (req_i.a[A_W-1:LO_W] == {HI_W{req_i.a[LO_W]}});

  always_comb begin
    priority if (hi_pass_q) begin
      part = PART_W'(signed'(req_i.a[A_W-1:LO_W]));
    end else if (fits) begin
      part = req_i.a[PART_W-1:0];
    end else begin
      part = {1'b0, req_i.a[LO_W-1:0]};
    end
  end

  assign prod = part * signed'({1'b0, req_i.b});
  assign prod_ext = P_W'(prod);
  assign p_d = hi_pass_q ? (p_q + (prod_ext <<< LO_W)) : prod_ext;
  assign hi_pass_d = req_i.go & ~hi_pass_q & ~fits;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hi_pass_q <= 1'b0;
    end else begin
      hi_pass_q <= hi_pass_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.go) begin
      p_q <= p_d;
    end
  end

  assign rsp_o.done = req_i.go & (hi_pass_q | fits);
  assign rsp_o.p = p_q;

  a_hi_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hi_pass_q |-> req_i.go)
    else $error("multiplier request dropped during high pass");

  a_hi_wide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hi_pass_q |-> !fits)
    else $error("operand changed during a split multiply");

  a_two_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hi_pass_q |=> !hi_pass_q)
    else $error("multiply took more than two passes");

endmodule

/* dv/sdlf_checker.sv */
`timescale 1ns / 100ps

module sdlf_checker #(
  parameter int STEPS_PER_TICK = sdlf_pkg::STEPS_PER_TICK_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  sdlf_in_if                             in_i,
  sdlf_out_if                            out_i,
  input  logic                           cfg_we_i,
  input  logic [sdlf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [sdlf_pkg::CFG_W-1:0]     cfg_data_i,
  output int                             fail_count_o,
  output int                             pending_o
);

  localparam int TGT_W = sdlf_pkg::TGT_W;
  localparam int DT_W = sdlf_pkg::DT_W;
  localparam int LEVEL_W = sdlf_pkg::LEVEL_W;
  localparam int VEL_W = sdlf_pkg::VEL_W;
  localparam int TRAIL_W = sdlf_pkg::TRAIL_W;
  localparam int GAIN_W = sdlf_pkg::GAIN_W;
  localparam int SNAP_W = sdlf_pkg::SNAP_W;
  localparam int FRAC_BITS = sdlf_pkg::FRAC_BITS;
  localparam longint VEL_LO = -(64'sd1 <<< (VEL_W - 1));
  localparam longint VEL_HI = (64'sd1 <<< (VEL_W - 1)) - 1;
  localparam longint TRAIL_LO = -(64'sd1 <<< (TRAIL_W - 1));
  localparam longint TRAIL_HI = (64'sd1 <<< (TRAIL_W - 1)) - 1;

  typedef struct packed {
    logic [TGT_W-1:0]          target;
    logic signed [TRAIL_W-1:0] trail;
    logic signed [VEL_W-1:0]   vel;
  } follower_t;

  typedef struct packed {
    logic signed [LEVEL_W-1:0] shown;
    logic signed [VEL_W-1:0]   vel;
  } level_result_t;

  logic [GAIN_W-1:0]       spring_gain = sdlf_pkg::SPRING_RST;
  logic [GAIN_W-1:0]       visc_gain = sdlf_pkg::VISC_RST;
  logic [SNAP_W-1:0]       snap_speed = sdlf_pkg::SNAP_RST;
  logic signed [VEL_W-1:0] vel_floor = sdlf_pkg::VFLOOR_RST;
  logic signed [VEL_W-1:0] vel_ceil = sdlf_pkg::VCEIL_RST;
  logic                    bounce = 1'b0;

  follower_t     follower = '0;
  level_result_t level_q[$];
  level_result_t want;
  int            fails = 0;

  function automatic longint clip(longint x, longint lo, longint hi);
    if (x < lo) return lo;
    if (x > hi) return hi;
    return x;
  endfunction

  // One item applied to the follower state.
  function automatic follower_t advance_follower(follower_t s, logic kind,
                                                 logic [TGT_W-1:0] tv,
                                                 logic [DT_W-1:0] dt);
    follower_t n;
    longint    tgt;
    longint    trail;
    longint    v;
    longint    gap;
    longint    pull;
    longint    drag;
    longint    step_dt;
    bit        at_edge;
    n = s;
    if (kind == sdlf_pkg::KIND_SET) begin
      v = longint'(s.vel) + longint'(tv) - longint'(s.target);
      n.vel = VEL_W'(clip(v, VEL_LO, VEL_HI));
      n.target = tv;
    end else begin
      tgt = longint'(s.target);
      trail = longint'(s.trail);
      v = longint'(s.vel);
      step_dt = longint'(dt);
      at_edge = (tgt == 0) || (tgt >= sdlf_pkg::ONE_Q);
      for (int i = 0; i < STEPS_PER_TICK; i++) begin
        gap = tgt - trail;
        if (at_edge) begin
          if (gap > 0) v = longint'(snap_speed);
          else if (gap < 0) v = -longint'(snap_speed);
          else v = 0;
        end else begin
          pull = (gap * longint'(spring_gain)) >>> FRAC_BITS;
          v = v + ((pull * step_dt) >>> FRAC_BITS);
          if (!bounce) begin
            drag = (-v * longint'(visc_gain)) >>> FRAC_BITS;
            v = v + ((drag * step_dt) >>> FRAC_BITS);
          end
        end
        // floor is checked first: when the limits cross, a value below the floor gets the floor
        if (v < longint'(vel_floor)) v = longint'(vel_floor);
        else if (v > longint'(vel_ceil)) v = longint'(vel_ceil);
        trail = clip(trail + ((v * step_dt) >>> FRAC_BITS), TRAIL_LO, TRAIL_HI);
      end
      trail = clip(trail, sdlf_pkg::LOW_CLAMP, sdlf_pkg::HIGH_CLAMP);
      n.vel = VEL_W'(v);
      n.trail = TRAIL_W'(trail);
    end
    return n;
  endfunction

  task automatic flag(string msg);
    fails++;
    $error("%s", msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spring_gain = sdlf_pkg::SPRING_RST;
      visc_gain = sdlf_pkg::VISC_RST;
      snap_speed = sdlf_pkg::SNAP_RST;
      vel_floor = sdlf_pkg::VFLOOR_RST;
      vel_ceil = sdlf_pkg::VCEIL_RST;
      bounce = 1'b0;
      follower = '0;
      level_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          sdlf_pkg::CFG_SPRING: spring_gain = cfg_data_i[GAIN_W-1:0];
          sdlf_pkg::CFG_VISC:   visc_gain = cfg_data_i[GAIN_W-1:0];
          sdlf_pkg::CFG_SNAP:   snap_speed = cfg_data_i[SNAP_W-1:0];
          sdlf_pkg::CFG_VFLOOR: vel_floor = cfg_data_i[VEL_W-1:0];
          sdlf_pkg::CFG_VCEIL:  vel_ceil = cfg_data_i[VEL_W-1:0];
          sdlf_pkg::CFG_BOUNCE: bounce = cfg_data_i[0];
          default: ;
        endcase
      end
      // older result leaves before the new item's result is queued
      if (out_i.valid && out_i.ready) begin
        if (level_q.size() == 0) begin
          flag($sformatf("result with no item pending: shown_level %0d velocity_now %0d",
                         out_i.shown_level, out_i.velocity_now));
        end else begin
          want = level_q.pop_front();
          if (out_i.shown_level !== want.shown)
            flag($sformatf("shown_level: expected %0d, got %0d",
                           want.shown, out_i.shown_level));
          if (out_i.velocity_now !== want.vel)
            flag($sformatf("velocity_now: expected %0d, got %0d",
                           want.vel, out_i.velocity_now));
        end
      end
      if (in_i.valid && in_i.ready) begin
        follower = advance_follower(follower, in_i.kind, in_i.target_value,
                                    in_i.time_step);
        level_q.insert(level_q.size(),
                       level_result_t'{shown: follower.trail[LEVEL_W-1:0],
                                       vel: follower.vel});
      end
      pending_o <= level_q.size();
    end
  end

  assign fail_count_o = fails;

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps

module tb;

  localparam int STEPS = sdlf_pkg::STEPS_PER_TICK_DEF;
  localparam int TGT_W = sdlf_pkg::TGT_W;
  localparam int DT_W = sdlf_pkg::DT_W;
  localparam int CFG_IDX_W = sdlf_pkg::CFG_IDX_W;
  localparam int CFG_W = sdlf_pkg::CFG_W;
  localparam int GAIN_W = sdlf_pkg::GAIN_W;
  localparam int SNAP_W = sdlf_pkg::SNAP_W;
  localparam int VEL_W = sdlf_pkg::VEL_W;
  localparam int ONE_Q = sdlf_pkg::ONE_Q;
  localparam int PHASE_ITEMS = 313;
  localparam int HOLD_CYCLES = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES = 200;

  typedef struct packed {
    logic             kind;
    logic [TGT_W-1:0] target_value;
    logic [DT_W-1:0]  time_step;
  } level_item_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;
  int                   fail_count;
  int                   pending;
  int                   src_idle = 15;
  int                   sink_idle = 55;
  bit                   hold_req = 1'b0;
  int                   quiet_cycles = 0;

  sdlf_in_if  in_ch ();
  sdlf_out_if out_ch ();

  spring_damped_level_follower_core #(
    .STEPS_PER_TICK(STEPS)
  ) DUT (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_ch),
    .out_o     (out_ch),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  sdlf_checker #(
    .STEPS_PER_TICK(STEPS)
  ) level_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_ch),
    .out_i       (out_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      out_ch.ready <= ($urandom_range(99) >= sink_idle);
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb failed");
        $finish;
      end
    end
  end

  task automatic send_item(input level_item_t it);
    if ($urandom_range(99) < src_idle) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= it.kind;
    in_ch.target_value <= it.target_value;
    in_ch.time_step <= it.time_step;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic send_set(input int tv);
    send_item('{kind: sdlf_pkg::KIND_SET, target_value: TGT_W'(tv),
                time_step: DT_W'($urandom)});
  endtask

  task automatic send_tick(input int dt);
    send_item('{kind: sdlf_pkg::KIND_TICK, target_value: TGT_W'($urandom),
                time_step: DT_W'(dt)});
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk_i);
  endtask

  task automatic load_regs(input logic [GAIN_W-1:0] spring, input logic [GAIN_W-1:0] visc,
                           input logic [SNAP_W-1:0] snap,
                           input logic signed [VEL_W-1:0] vfloor,
                           input logic signed [VEL_W-1:0] vceil, input logic bounce);
    put_reg(sdlf_pkg::CFG_SPRING, CFG_W'(spring));
    put_reg(sdlf_pkg::CFG_VISC, CFG_W'(visc));
    put_reg(sdlf_pkg::CFG_SNAP, CFG_W'(snap));
    put_reg(sdlf_pkg::CFG_VFLOOR, CFG_W'(vfloor));
    put_reg(sdlf_pkg::CFG_VCEIL, CFG_W'(vceil));
    put_reg(sdlf_pkg::CFG_BOUNCE, CFG_W'(bounce));
    cfg_we <= 1'b0;
  endtask

  function automatic level_item_t pick_item();
    level_item_t it;
    int unsigned roll;
    it.target_value = TGT_W'($urandom);
    it.time_step = DT_W'($urandom);
    it.kind = ($urandom_range(3) == 0) ? sdlf_pkg::KIND_SET : sdlf_pkg::KIND_TICK;
    roll = $urandom_range(99);
    if (it.kind == sdlf_pkg::KIND_SET) begin
      if (roll < 60) it.target_value = TGT_W'($urandom_range(ONE_Q - 1, 1));
      else if (roll < 72) it.target_value = '0;
      else if (roll < 84) it.target_value = TGT_W'(ONE_Q);
    end else begin
      if (roll < 50) it.time_step = DT_W'($urandom_range(4095));
      else if (roll < 55) it.time_step = '0;
      else if (roll < 60) it.time_step = '1;
    end
    return it;
  endfunction

  task automatic run_phase(input int hold_at, input int pause_at);
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      if (i == hold_at) hold_req = 1'b1;
      if (i == pause_at) drain();
      send_item(pick_item());
    end
    drain();
  endtask

  initial begin
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.kind = sdlf_pkg::KIND_SET;
    in_ch.target_value = '0;
    in_ch.time_step = '0;
    cfg_we = 1'b0;
    cfg_idx = sdlf_pkg::CFG_SPRING;
    cfg_data = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, default registers
    send_tick(1000);
    send_set(ONE_Q);
    send_tick(65535);
    send_tick(0);
    send_set(0);
    send_tick(1000);
    send_set(131071);
    send_tick(65535);
    send_set(32768);
    send_tick(0);
    send_tick(65535);
    send_set(32768);
    send_tick(300);
    send_set(1);
    send_tick(65535);
    drain();

    // directed, widest limits: drive velocity to the top, then saturate on a jump
    load_regs('1, '1, '1, 20'sh80000, 20'sd524287, 1'b0);
    send_set(0);
    send_tick(65535);
    send_tick(1);
    send_set(131071);
    send_tick(30000);
    send_set(20000);
    send_tick(65535);
    drain();

    load_regs(sdlf_pkg::SPRING_RST, sdlf_pkg::VISC_RST, sdlf_pkg::SNAP_RST,
              sdlf_pkg::VFLOOR_RST, sdlf_pkg::VCEIL_RST, 1'b0);
    run_phase(-1, -1);
    load_regs('1, '1, '1, 20'sh80000, 20'sd524287, 1'b0);
    run_phase(100, -1);

    src_idle = 55;
    sink_idle = 15;
    load_regs('0, '0, '0, '0, '0, 1'b1);
    run_phase(-1, -1);
    load_regs(24'd196608, 24'd0, 19'd40000, 20'sd20000, -20'sd20000, 1'b0);
    run_phase(-1, 150);

    src_idle = 0;
    sink_idle = 0;
    load_regs(GAIN_W'($urandom_range(1048576)), GAIN_W'($urandom_range(524288)),
              SNAP_W'($urandom), -VEL_W'($urandom_range(400000)),
              VEL_W'($urandom_range(400000)), 1'b1);
    run_phase(-1, -1);
    load_regs(GAIN_W'($urandom), GAIN_W'($urandom), SNAP_W'($urandom),
              VEL_W'($urandom), VEL_W'($urandom), 1'($urandom));
    run_phase(-1, -1);

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

/* spring_damped_level_follower_core.f */
rtl/sdlf_pkg.sv
rtl/sdlf_in_if.sv
rtl/sdlf_out_if.sv
rtl/sdlf_mul.sv
rtl/spring_damped_level_follower_core.sv
dv/sdlf_checker.sv
dv/tb.sv
